// ===== rtl/dqpc_pkg.sv =====
`default_nettype none

package dqpc_pkg;

    localparam int PHASE_W   = 2;
    localparam int TICK_W    = 2;
    localparam int POS_OUT_W = 10;
    localparam int STEP_W    = 3;

    localparam logic [STEP_W-1:0] STEP_RESET = 3'd1;

    localparam int EDGES_PER_DETENT_DEF = 4;
    localparam int POSITION_MAX_DEF     = 1023;

    typedef logic [TICK_W-1:0] tick_t;

    localparam tick_t TICK_NONE = 2'd0;
    localparam tick_t TICK_CCW  = 2'd1;
    localparam tick_t TICK_CW   = 2'd2;

    typedef struct packed {
        tick_t tick_a;
        tick_t tick_b;
    } ticks_t;

    typedef struct packed {
        logic [POS_OUT_W-1:0] position;
        tick_t                tick_a;
        tick_t                tick_b;
    } result_t;

    // Gray-code successor of a phase when turning ccw
    function automatic logic [PHASE_W-1:0] ccw_next(input logic [PHASE_W-1:0] phase);
        logic [PHASE_W-1:0] nxt;
        unique case (phase)
            2'd0:    nxt = 2'd2;
            2'd1:    nxt = 2'd0;
            2'd2:    nxt = 2'd3;
            default: nxt = 2'd1;
        endcase
        return nxt;
    endfunction

    // Gray-code successor of a phase when turning cw
    function automatic logic [PHASE_W-1:0] cw_next(input logic [PHASE_W-1:0] phase);
        logic [PHASE_W-1:0] nxt;
        unique case (phase)
            2'd0:    nxt = 2'd1;
            2'd1:    nxt = 2'd3;
            2'd2:    nxt = 2'd0;
            default: nxt = 2'd2;
        endcase
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dqpc_if.sv =====
`default_nettype none

interface dqpc_in_if;
    import dqpc_pkg::*;
    logic               valid;
    logic               ready;
    logic [PHASE_W-1:0] phase_a;
    logic [PHASE_W-1:0] phase_b;
    modport source (output valid, output phase_a, output phase_b, input ready);
    modport sink   (input valid, input phase_a, input phase_b, output ready);
endinterface

interface dqpc_out_if;
    import dqpc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [POS_OUT_W-1:0] position;
    tick_t                tick_a;
    tick_t                tick_b;
    modport source (output valid, output position, output tick_a, output tick_b,
                    input ready);
    modport sink   (input valid, input position, input tick_a, input tick_b,
                    output ready);
endinterface

interface dqpc_cfg_if;
    import dqpc_pkg::*;
    logic              valid;
    logic              ready;
    logic [STEP_W-1:0] step_size;
    modport source (output valid, output step_size, input ready);
    modport sink   (input valid, input step_size, output ready);
endinterface

`default_nettype wire

// ===== rtl/dqpc_lane.sv =====
`default_nettype none

module dqpc_lane #(
    parameter int EDGES_PER_DETENT = dqpc_pkg::EDGES_PER_DETENT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic [dqpc_pkg::PHASE_W-1:0] phase,
    output dqpc_pkg::tick_t                    tick
);
    import dqpc_pkg::*;

    // signed counter holds -(E-1)..E-1, transiently +-E
    localparam int EDGE_W = $clog2(EDGES_PER_DETENT + 1) + 1;
    localparam logic signed [EDGE_W-1:0] EDGE_LIM = EDGE_W'(EDGES_PER_DETENT);
    localparam logic signed [EDGE_W-1:0] EDGE_ONE = EDGE_W'(1);

    logic [PHASE_W-1:0]       last_phase_reg;
    logic signed [EDGE_W-1:0] edges_reg;
    logic signed [EDGE_W-1:0] edges_step;
    logic signed [EDGE_W-1:0] edges_next;

    always_comb
    begin
        edges_step = edges_reg;
        if (phase == ccw_next(last_phase_reg))
        begin
            edges_step = edges_reg + EDGE_ONE;
        end
        else if (phase == cw_next(last_phase_reg))
        begin
            edges_step = edges_reg - EDGE_ONE;
        end

        edges_next = edges_step;
        tick       = TICK_NONE;
        if (edges_step >= EDGE_LIM)
        begin
            edges_next = '0;
            tick       = TICK_CCW;
        end
        else if (edges_step <= -EDGE_LIM)
        begin
            edges_next = '0;
            tick       = TICK_CW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_phase_reg <= '0;
            edges_reg      <= '0;
        end
        else if (advance)
        begin
            last_phase_reg <= phase;
            edges_reg      <= edges_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dqpc_merge.sv =====
`default_nettype none

module dqpc_merge #(
    parameter int POSITION_MAX = dqpc_pkg::POSITION_MAX_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           advance,
    input  wire logic [dqpc_pkg::STEP_W-1:0]    step_size,
    input  wire dqpc_pkg::ticks_t               ticks,
    output logic [dqpc_pkg::POS_OUT_W-1:0]      position
);
    import dqpc_pkg::*;

    localparam int POS_W = (POSITION_MAX < 2) ? 1 : $clog2(POSITION_MAX + 1);
    // headroom for two steps either way
    localparam int ACC_W = POS_W + 5;
    localparam logic signed [ACC_W-1:0] POS_LIM = ACC_W'(POSITION_MAX);

    logic [POS_W-1:0]        position_reg;
    logic [POS_W-1:0]        position_next;
    logic signed [ACC_W-1:0] step_ext;
    logic signed [ACC_W-1:0] after_a;
    logic signed [ACC_W-1:0] after_b;

    function automatic logic signed [ACC_W-1:0] apply_tick(
        input logic signed [ACC_W-1:0] acc,
        input tick_t                   tick,
        input logic signed [ACC_W-1:0] step
    );
        logic signed [ACC_W-1:0] res;
        res = acc;
        if (tick == TICK_CCW)
        begin
            res = acc + step;
        end
        else if (tick == TICK_CW)
        begin
            res = acc - step;
        end
        return res;
    endfunction

    always_comb
    begin
        step_ext = $signed({{(ACC_W - STEP_W){1'b0}}, step_size});
        after_a  = apply_tick($signed({{(ACC_W - POS_W){1'b0}}, position_reg}),
                              ticks.tick_a, step_ext);
        after_b  = apply_tick(after_a, ticks.tick_b, step_ext);

        // forced jump, not a modular wrap
        priority if (after_b > POS_LIM)
        begin
            position_next = '0;
        end
        else if (after_b < 0)
        begin
            position_next = POS_W'(POSITION_MAX);
        end
        else
        begin
            position_next = after_b[POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= POS_W'(1);
        end
        else if (advance)
        begin
            position_reg <= position_next;
        end
    end

    assign position = POS_OUT_W'(position_next);

endmodule

`default_nettype wire

// ===== rtl/dual_quadrature_position_counter.sv =====
// Channel   | Dir | Payload                          | Transaction when
// ----------+-----+----------------------------------+---------------------------
// sample    | in  | phase_a[1:0], phase_b[1:0]       | sample.valid & sample.ready
// result    | out | position[9:0], tick_a, tick_b    | result.valid & result.ready
// cfg       | in  | step_size[2:0]                   | cfg.valid & cfg.ready
//
// One sample per clock while sample.ready is high; each result is registered
// into the output buffer. Throughput is bound by the merge-stage position
// feedback. Reset (rst_n low, async): phases and edge counters 0, position 1,
// step_size 1. A two-entry output buffer lets samples flow on in a result
// stall; sample.ready drops only when both entries are full. cfg is always ready.
`default_nettype none

module dual_quadrature_position_counter #(
    parameter int EDGES_PER_DETENT = dqpc_pkg::EDGES_PER_DETENT_DEF,
    parameter int POSITION_MAX     = dqpc_pkg::POSITION_MAX_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dqpc_in_if.sink     sample,
    dqpc_out_if.source  result,
    dqpc_cfg_if.sink    cfg
);
    import dqpc_pkg::*;

    logic [STEP_W-1:0]    step_size_reg;
    logic                 advance;
    logic                 pop;
    tick_t                tick_a;
    tick_t                tick_b;
    ticks_t               ticks;
    logic [POS_OUT_W-1:0] position;
    result_t              new_res;

    // output buffer: head entry drives the port, skid entry queues behind it
    result_t head_reg;
    result_t skid_reg;
    logic    head_valid_reg;
    logic    skid_valid_reg;

    assign cfg.ready    = 1'b1;
    assign sample.ready = !skid_valid_reg;
    assign advance      = sample.valid && sample.ready;
    assign pop          = head_valid_reg && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg <= STEP_RESET;
        end
        else if (cfg.valid)
        begin
            step_size_reg <= cfg.step_size;
        end
    end

    // one lane per encoder
    dqpc_lane #(
        .EDGES_PER_DETENT (EDGES_PER_DETENT)
    ) u_lane_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .phase   (sample.phase_a),
        .tick    (tick_a)
    );

    dqpc_lane #(
        .EDGES_PER_DETENT (EDGES_PER_DETENT)
    ) u_lane_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .phase   (sample.phase_b),
        .tick    (tick_b)
    );

    assign ticks = {tick_a, tick_b};

    // A's tick applies before B's, then the jump correction
    dqpc_merge #(
        .POSITION_MAX (POSITION_MAX)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .step_size (step_size_reg),
        .ticks     (ticks),
        .position  (position)
    );

    always_comb
    begin
        new_res.position = position;
        new_res.tick_a   = tick_a;
        new_res.tick_b   = tick_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= advance;
            end
            else
            begin
                head_valid_reg <= advance;
            end
        end
        else if (advance)
        begin
            if (head_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                head_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_reg <= skid_reg;
                if (advance)
                begin
                    skid_reg <= new_res;
                end
            end
            else if (advance)
            begin
                head_reg <= new_res;
            end
        end
        else if (advance)
        begin
            if (head_valid_reg)
            begin
                skid_reg <= new_res;
            end
            else
            begin
                head_reg <= new_res;
            end
        end
    end

    assign result.valid    = head_valid_reg;
    assign result.position = head_reg.position;
    assign result.tick_a   = head_reg.tick_a;
    assign result.tick_b   = head_reg.tick_b;

endmodule

`default_nettype wire

// ===== rtl/dqpc_checker.sv =====
`default_nettype none

module dqpc_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_valid,
    input wire logic                           s_ready,
    input wire logic                           r_valid,
    input wire logic                           r_ready,
    input wire logic [dqpc_pkg::POS_OUT_W-1:0] r_position,
    input wire dqpc_pkg::tick_t                r_tick_a,
    input wire dqpc_pkg::tick_t                r_tick_b
);
    import dqpc_pkg::*;

    // stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable(r_position)
            && $stable(r_tick_a) && $stable(r_tick_b))
        else $error("stalled result changed");

    // with nothing buffered the block must take samples
    assert property (@(posedge clk) disable iff (!rst_n)
        !r_valid |-> s_ready)
        else $error("empty block not ready");

    // a sample into an empty buffer shows up next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_valid && s_ready && !r_valid |=> r_valid)
        else $error("result missing after sample");

    // only none, ccw or cw tick codes
    assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |->
            (r_tick_a == TICK_NONE || r_tick_a == TICK_CCW || r_tick_a == TICK_CW) &&
            (r_tick_b == TICK_NONE || r_tick_b == TICK_CCW || r_tick_b == TICK_CW))
        else $error("illegal tick code");

endmodule

bind dual_quadrature_position_counter dqpc_checker u_dqpc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .s_valid    (sample.valid),
    .s_ready    (sample.ready),
    .r_valid    (result.valid),
    .r_ready    (result.ready),
    .r_position (result.position),
    .r_tick_a   (result.tick_a),
    .r_tick_b   (result.tick_b)
);

`default_nettype wire

// ===== test/dqpc_tb_pkg.sv =====
package dqpc_tb_pkg;
    import dqpc_pkg::*;

    // Shadow of the counter: per-encoder phase and edge count, shared position.
    class position_scoreboard;
        logic [STEP_W-1:0]  step_size;
        logic [PHASE_W-1:0] prev_phase [2];
        int                 detent_edges [2];
        int                 position;
        result_t            predicted_results [$];
        int unsigned        mismatches;

        function new();
            step_size    = STEP_RESET;
            prev_phase   = '{2'd0, 2'd0};
            detent_edges = '{0, 0};
            position     = 1;
            mismatches   = 0;
        endfunction

        function void set_step(input logic [STEP_W-1:0] value);
            step_size = value;
        endfunction

        function int unsigned pending();
            return predicted_results.size();
        endfunction

        // Gray order 00 -> 10 -> 11 -> 01 is ccw; the reverse is cw.
        function tick_t advance_encoder(input int unsigned idx, input logic [PHASE_W-1:0] phase);
            logic [PHASE_W-1:0] old;
            tick_t              tick;
            old             = prev_phase[idx];
            tick            = TICK_NONE;
            prev_phase[idx] = phase;
            if (phase != old)
            begin
                if (phase == {~old[0], old[1]})
                    detent_edges[idx]++;
                else if (phase == {old[0], ~old[1]})
                    detent_edges[idx]--;
                if (detent_edges[idx] >= EDGES_PER_DETENT_DEF)
                begin
                    detent_edges[idx] = 0;
                    tick              = TICK_CCW;
                end
                else if (detent_edges[idx] <= -EDGES_PER_DETENT_DEF)
                begin
                    detent_edges[idx] = 0;
                    tick              = TICK_CW;
                end
            end
            return tick;
        endfunction

        function void move_position(input tick_t tick);
            if (tick == TICK_CCW)
                position += int'(step_size);
            else if (tick == TICK_CW)
                position -= int'(step_size);
        endfunction

        function void note_sample(input logic [PHASE_W-1:0] pa, input logic [PHASE_W-1:0] pb);
            result_t r;
            r.tick_a = advance_encoder(0, pa);
            move_position(r.tick_a);
            r.tick_b = advance_encoder(1, pb);
            move_position(r.tick_b);
            // forced jump, not a modular wrap
            if (position > POSITION_MAX_DEF)
                position = 0;
            if (position < 0)
                position = POSITION_MAX_DEF;
            r.position = position[POS_OUT_W-1:0];
            predicted_results.push_back(r);
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (predicted_results.size() == 0)
            begin
                $error("unexpected result: position %0d tick_a %0d tick_b %0d",
                       got.position, got.tick_a, got.tick_b);
                mismatches++;
                return;
            end
            want = predicted_results.pop_front();
            if (got.position !== want.position)
            begin
                $error("position: expected %0d, got %0d", want.position, got.position);
                mismatches++;
            end
            if (got.tick_a !== want.tick_a)
            begin
                $error("tick_a: expected %0d, got %0d", want.tick_a, got.tick_a);
                mismatches++;
            end
            if (got.tick_b !== want.tick_b)
            begin
                $error("tick_b: expected %0d, got %0d", want.tick_b, got.tick_b);
                mismatches++;
            end
        endfunction
    endclass

endpackage

// ===== test/tb_dual_quadrature_position_counter.sv =====
module tb_dual_quadrature_position_counter;
    timeunit 1ns;
    timeprecision 1ps;

    import dqpc_pkg::*;
    import dqpc_tb_pkg::*;

    // Cycles allowed after the last result before a register write or the end.
    localparam int SETTLE_CYCLES = 4;
    localparam int ITEMS_PER_SETTING = 120;

    logic clk;
    logic rst_n;

    dqpc_in_if  smp ();
    dqpc_out_if res ();
    dqpc_cfg_if cfg_bus ();

    position_scoreboard board = new();

    dual_quadrature_position_counter DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (smp),
        .result (res),
        .cfg    (cfg_bus)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Idle length for either side: mostly none or short, sometimes long,
    // and now and then a calm stretch with no idling at all.
    function automatic int unsigned pick_idle(inout int unsigned calm_left);
        int unsigned roll;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 79) == 0)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 25);
    endfunction

    // Next phase of one encoder. Mostly keeps turning in its current
    // direction so edge counts build up to detents; the rest is holds,
    // two-bit jumps (ignored steps) and arbitrary phases.
    function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] cur,
                                                      inout tick_t dir);
        int unsigned roll;
        if ($urandom_range(0, 19) == 0)
        begin
            if ($urandom_range(0, 9) == 0)
                dir = TICK_NONE;
            else
                dir = $urandom_range(0, 1) ? TICK_CCW : TICK_CW;
        end
        roll = $urandom_range(0, 99);
        if (roll < 80)
        begin
            if (dir == TICK_CCW)
                return {~cur[0], cur[1]};
            else if (dir == TICK_CW)
                return {cur[0], ~cur[1]};
            else
                return cur;
        end
        else if (roll < 88)
            return cur;
        else if (roll < 94)
            return cur ^ 2'b11;
        else
            return PHASE_W'($urandom_range(0, 3));
    endfunction

    int unsigned send_calm;
    int unsigned recv_calm;

    // One sample transaction. Called and returns at a falling edge; valid
    // stays high on return so back-to-back samples run without a gap.
    task automatic send_sample(input logic [PHASE_W-1:0] pa, input logic [PHASE_W-1:0] pb);
        int unsigned idle;
        idle = pick_idle(send_calm);
        if (idle > 0)
        begin
            smp.valid = 1'b0;
            repeat (idle) @(negedge clk);
        end
        smp.valid   = 1'b1;
        smp.phase_a = pa;
        smp.phase_b = pb;
        do
            @(posedge clk);
        while (!smp.ready);
        board.note_sample(pa, pb);
        @(negedge clk);
    endtask

    // Hold off the sender until every predicted result has been seen.
    task automatic drain_results();
        smp.valid = 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Register write, only issued with the block idle.
    task automatic write_step(input logic [STEP_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_bus.valid     = 1'b1;
        cfg_bus.step_size = value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        board.set_step(value);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // Result side backpressure, changed at falling edges.
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        recv_calm  = 0;
        res.ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                res.ready  = 1'b1;
                stall_left = pick_idle(recv_calm);
            end
        end
    end

    // Every result transaction is checked against the oldest prediction.
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && res.valid && res.ready)
        begin
            got.position = res.position;
            got.tick_a   = res.tick_a;
            got.tick_b   = res.tick_b;
            board.check_result(got);
        end
    end

    initial
    begin
        // Directed: holds, two-bit jumps, a cw detent on each encoder taking
        // the position 1 -> 0 -> below zero (jumps to the top), a ccw detent
        // on both at once going over the top (jumps to 0), opposite detents
        // in one sample, and a partial turn reversed back to zero edges.
        static logic [2*PHASE_W-1:0] directed_seq [25] = '{
            4'b00_00, 4'b11_11, 4'b00_00,
            4'b01_00, 4'b11_00, 4'b10_00, 4'b00_00,
            4'b00_01, 4'b00_11, 4'b00_10, 4'b00_00,
            4'b10_10, 4'b11_11, 4'b01_01, 4'b00_00,
            4'b10_01, 4'b11_11, 4'b01_10, 4'b00_00,
            4'b10_00, 4'b11_00, 4'b01_00, 4'b11_00, 4'b10_00, 4'b00_00
        };
        // Step sizes, including zero and the largest; every 3-bit code appears.
        static logic [STEP_W-1:0] step_plan [10] = '{
            3'd0, 3'd4, 3'd2, 3'd7, 3'd1, 3'd3, 3'd5, 3'd6, 3'd4, 3'd2
        };
        logic [PHASE_W-1:0] cur_a;
        logic [PHASE_W-1:0] cur_b;
        tick_t              dir_a;
        tick_t              dir_b;

        rst_n             = 1'b0;
        smp.valid         = 1'b0;
        smp.phase_a       = '0;
        smp.phase_b       = '0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.step_size = '0;
        send_calm         = 0;
        cur_a             = '0;
        cur_b             = '0;
        dir_a             = TICK_CCW;
        dir_b             = TICK_CW;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part runs on the reset step size.
        foreach (directed_seq[i])
        begin
            cur_a = directed_seq[i][3:2];
            cur_b = directed_seq[i][1:0];
            send_sample(cur_a, cur_b);
        end

        foreach (step_plan[s])
        begin
            write_step(step_plan[s]);
            repeat (ITEMS_PER_SETTING)
            begin
                cur_a = next_phase(cur_a, dir_a);
                cur_b = next_phase(cur_b, dir_b);
                send_sample(cur_a, cur_b);
                if ($urandom_range(0, 149) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (board.mismatches == 0 && board.pending() == 0)
        begin
            $display("tb_dual_quadrature_position_counter: PASS");
        end
        else
        begin
            if (board.pending() != 0)
                $error("%0d predicted results never arrived", board.pending());
            $display("tb_dual_quadrature_position_counter: FAIL");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("tb_dual_quadrature_position_counter: FAIL");
        $finish;
    end

endmodule
